@@ rtl/sdcd_pkg.sv @@
`timescale 1ns / 1ps
package sdcd_pkg;

  localparam int unsigned MAX_SERIAL_DAYS = 65536;
  localparam int unsigned SERIAL_W = 20;
  localparam int unsigned LIMIT_W = 21;

  localparam logic [12:0] EPOCH_YEAR = 13'd1900;
  localparam logic [5:0] EPOCH_CENT = 6'd19;
  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [12:0] YEAR_LIMIT = 13'd4095;
  localparam logic [19:0] YEARS_PER_CENT = 20'd100;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  typedef struct packed {
    logic [19:0] serial_day;
    logic [11:0] given_year;
    logic [3:0]  given_month;
    logic [5:0]  given_day;
  } req_t;

  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [1:0] year_lo;
    logic [5:0] cent_q;
    logic [11:0] cent_r;
    logic [3:0] month;
  } cal_in_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m) inside
      4'd2: n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/sdcd_alu.sv @@
`timescale 1ns / 1ps
module sdcd_alu (
  input  logic [sdcd_pkg::SERIAL_W-1:0] a,
  input  logic [sdcd_pkg::SERIAL_W-1:0] b,
  output logic [sdcd_pkg::SERIAL_W-1:0] diff,
  output logic                          lt
);
  import sdcd_pkg::*;

  logic [SERIAL_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[SERIAL_W-1:0];
  assign lt = wide[SERIAL_W];

endmodule

@@ rtl/sdcd_cal.sv @@
`timescale 1ns / 1ps
module sdcd_cal (
  input  sdcd_pkg::cal_in_t cal,
  output logic [4:0]        len
);
  import sdcd_pkg::*;

  logic leap;

  // year = 100*cent_q + cent_r
  assign leap = (cal.year_lo == 2'd0 && cal.cent_r != 12'd0) ||
                (cal.cent_r == 12'd0 && cal.cent_q[1:0] == 2'd0);
  assign len = month_len(cal.month, leap);

endmodule

@@ rtl/serial_day_to_calendar_date_core.sv @@
`timescale 1ns / 1ps
// Serial day count to calendar date converter.
// Request channel: req_valid / req_stall / req_data. A request is taken when
// req_valid is high and req_stall low; req_stall is high while a request is
// in work, so one request is handled at a time.
// Result channel: res_valid / res_stall / res_data, one result per request,
// held in an output register until taken.
// A serial from 2 to 65535 walks whole months from January 1900 through
// one shared subtractor, one month per cycle.
// A zero serial reduces the given year by 100 per cycle to find its century,
// then checks the day.
// Out-of-range serials and serial one go straight to the finish state.
// The next request is taken as soon as the result is loaded into the output
// register; a stalled result holds and blocks only the completion of the
// following request.
// Reset (rst, synchronous) drops res_valid and returns the sequencer to idle.
module serial_day_to_calendar_date_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  sdcd_pkg::req_t   req_data,
  output logic             res_valid,
  input  logic             res_stall,
  output sdcd_pkg::res_t   res_data
);
  import sdcd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_CHECK  = 5'b00100,
    S_WALK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [12:0] year, year_next;
  logic [3:0]  month, month_next;
  logic [5:0]  day, day_next;
  logic [19:0] rest, rest_next;
  logic [5:0]  cent_q, cent_q_next;
  logic [11:0] cent_r, cent_r_next;
  logic [1:0]  st, st_next;

  logic [19:0] alu_a, alu_b, alu_diff;
  logic        alu_lt;
  logic [4:0]  len;
  cal_in_t     cal;
  logic        take, load;
  logic [1:0]  st_final;

  assign req_stall = (state != S_IDLE);
  assign take = req_valid && (state == S_IDLE);
  assign load = (state == S_FINISH) && (!res_valid || !res_stall);

  assign cal = '{year_lo: year[1:0], cent_q: cent_q, cent_r: cent_r, month: month};

  sdcd_cal u_cal (
    .cal (cal),
    .len (len)
  );

  always_comb begin
    unique case (state)
      S_DIV: begin
        alu_a = {8'd0, cent_r};
        alu_b = YEARS_PER_CENT;
      end
      S_CHECK: begin
        alu_a = {15'd0, len};
        alu_b = {14'd0, day};
      end
      S_WALK: begin
        alu_a = rest;
        alu_b = {15'd0, len};
      end
      default: begin
        alu_a = req_data.serial_day;
        alu_b = 20'd2;
      end
    endcase
  end

  sdcd_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .lt   (alu_lt)
  );

  always_comb begin
    state_next = state;
    year_next = year;
    month_next = month;
    day_next = day;
    rest_next = rest;
    cent_q_next = cent_q;
    cent_r_next = cent_r;
    st_next = st;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          st_next = ST_VALID;
          if (req_data.serial_day != 20'd0) begin
            if ({1'b0, req_data.serial_day} >= LIMIT_W'(MAX_SERIAL_DAYS)) begin
              st_next = ST_TOO_BIG;
              state_next = S_FINISH;
            end else if (alu_lt) begin
              st_next = ST_INVALID;
              state_next = S_FINISH;
            end else begin
              rest_next = alu_diff;
              year_next = EPOCH_YEAR;
              month_next = 4'd1;
              cent_q_next = EPOCH_CENT;
              cent_r_next = 12'd0;
              state_next = S_WALK;
            end
          end else begin
            year_next = {1'b0, req_data.given_year};
            month_next = req_data.given_month;
            day_next = req_data.given_day;
            cent_q_next = 6'd0;
            cent_r_next = req_data.given_year;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (alu_lt) begin
          state_next = S_CHECK;
        end else begin
          cent_r_next = alu_diff[11:0];
          cent_q_next = cent_q + 6'd1;
        end
      end
      S_CHECK: begin
        state_next = S_FINISH;
        if (month == 4'd0 || month > MONTHS_PER_YEAR || day == 6'd0) begin
          st_next = ST_INVALID;
        end else if (alu_lt) begin
          day_next = 6'd1;
          if (month == MONTHS_PER_YEAR) begin
            month_next = 4'd1;
            year_next = year + 13'd1;
          end else begin
            month_next = month + 4'd1;
          end
        end
      end
      S_WALK: begin
        if (alu_lt) begin
          day_next = {1'b0, rest[4:0]} + 6'd1;
          state_next = S_FINISH;
        end else begin
          rest_next = alu_diff;
          if (month == MONTHS_PER_YEAR) begin
            month_next = 4'd1;
            year_next = year + 13'd1;
            if (cent_r == 12'd99) begin
              cent_r_next = 12'd0;
              cent_q_next = cent_q + 6'd1;
            end else begin
              cent_r_next = cent_r + 12'd1;
            end
          end else begin
            month_next = month + 4'd1;
          end
        end
      end
      S_FINISH: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign st_final = (st == ST_VALID && year > YEAR_LIMIT) ? ST_INVALID : st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    year <= year_next;
    month <= month_next;
    day <= day_next;
    rest <= rest_next;
    cent_q <= cent_q_next;
    cent_r <= cent_r_next;
    st <= st_next;
    if (load) begin
      res_data.status <= st_final;
      if (st_final == ST_VALID) begin
        res_data.out_day <= day[4:0];
        res_data.out_month <= month;
        res_data.out_year <= year[11:0];
      end else begin
        res_data.out_day <= 5'd0;
        res_data.out_month <= 4'd0;
        res_data.out_year <= 12'd0;
      end
    end
  end

endmodule

@@ sim/calendar_date_checker.sv @@
`timescale 1ns / 1ps
module calendar_date_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  sdcd_pkg::req_t req_data,
  input  logic           res_valid,
  input  logic           res_stall,
  input  sdcd_pkg::res_t res_data,
  output int             date_errors,
  output int             outstanding
);
  import sdcd_pkg::*;

  localparam int unsigned JANUARY = 1;
  localparam int unsigned FEBRUARY = 2;
  // serial of 1 January 1900
  localparam int unsigned SERIAL_ORIGIN = 2;

  res_t expected_dates[$];

  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in(int unsigned y, int unsigned m);
    int unsigned n;
    case (m) inside
      FEBRUARY: n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default: n = 31;
    endcase
    return n;
  endfunction

  function automatic res_t calendar_of(req_t r);
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned rest;
    logic [1:0] st;
    res_t o;
    yr = r.given_year;
    mo = r.given_month;
    dy = r.given_day;
    st = ST_VALID;
    if (r.serial_day != 0) begin
      if (r.serial_day >= MAX_SERIAL_DAYS) begin
        st = ST_TOO_BIG;
      end else if (r.serial_day < SERIAL_ORIGIN) begin
        st = ST_INVALID;
      end else begin
        rest = r.serial_day - SERIAL_ORIGIN;
        yr = EPOCH_YEAR;
        mo = JANUARY;
        while (rest >= days_in(yr, mo)) begin
          rest -= days_in(yr, mo);
          if (mo == MONTHS_PER_YEAR) begin
            mo = JANUARY;
            yr++;
          end else begin
            mo++;
          end
        end
        dy = rest + 1;
      end
    end else if (mo == 0 || mo > MONTHS_PER_YEAR || dy == 0) begin
      st = ST_INVALID;
    end else begin
      // day overrun rolls to the 1st of the next month
      if (dy > days_in(yr, mo)) begin
        mo++;
        dy = 1;
      end
      if (mo > MONTHS_PER_YEAR) begin
        yr++;
        mo = JANUARY;
      end
    end
    if (st == ST_VALID && yr > YEAR_LIMIT) st = ST_INVALID;
    o = '0;
    o.status = st;
    if (st == ST_VALID) begin
      o.out_day = 5'(dy);
      o.out_month = 4'(mo);
      o.out_year = 12'(yr);
    end
    return o;
  endfunction

  initial begin
    date_errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (req_valid && !req_stall) expected_dates.push_back(calendar_of(req_data));
      if (res_valid && !res_stall) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result with no request pending: day=%0d month=%0d year=%0d status=%0d",
                   $time, res_data.out_day, res_data.out_month, res_data.out_year,
                   res_data.status);
          date_errors <= date_errors + 1;
        end else begin
          want = expected_dates.pop_front();
          if (want.out_day !== res_data.out_day || want.out_month !== res_data.out_month ||
              want.out_year !== res_data.out_year || want.status !== res_data.status) begin
            $display("%0t: mismatch expected d=%0d m=%0d y=%0d st=%0d actual d=%0d m=%0d y=%0d st=%0d",
                     $time, want.out_day, want.out_month, want.out_year, want.status,
                     res_data.out_day, res_data.out_month, res_data.out_year, res_data.status);
            date_errors <= date_errors + 1;
          end
        end
      end
      outstanding <= expected_dates.size();
    end
  end

endmodule

@@ sim/serial_day_to_calendar_date_core_tb.sv @@
`timescale 1ns / 1ps
module serial_day_to_calendar_date_core_tb;
  import sdcd_pkg::*;

  localparam int RANDOM_REQUESTS = 100;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic res_valid;
  logic res_stall;
  res_t res_data;

  int date_errors;
  int outstanding;
  int hold_ticket;
  int cycle_count;
  int burst_left;

  serial_day_to_calendar_date_core DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

  calendar_date_checker checker_i (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .date_errors(date_errors),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    res_stall = 1'b0;
    hold_ticket = 0;
    cycle_count = 0;
    burst_left = 0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("serial_day_to_calendar_date_core_tb NOT OK");
      $finish;
    end
  end

  function automatic req_t date_req(int unsigned s, int unsigned y, int unsigned m,
                                    int unsigned d);
    req_t r;
    r.serial_day = 20'(s);
    r.given_year = 12'(y);
    r.given_month = 4'(m);
    r.given_day = 6'(d);
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    r = date_req(0, $urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // mostly well-formed dates near the month end
      if ($urandom_range(0, 3) != 0) begin
        r.given_month = 4'($urandom_range(1, 12));
        r.given_day = 6'($urandom_range(26, 33));
        if ($urandom_range(0, 7) == 0) r.given_year = 12'd4095;
      end
    end else if (pick < 75) begin
      r.serial_day = 20'($urandom_range(2, 4000));
    end else if (pick < 88) begin
      r.serial_day = 20'($urandom_range(2, MAX_SERIAL_DAYS - 1));
    end else if (pick < 97) begin
      r.serial_day = 20'($urandom_range(MAX_SERIAL_DAYS, 20'hFFFFF));
    end else begin
      r.serial_day = 20'd1;
    end
    return r;
  endfunction

  task automatic offer(req_t r);
    int unsigned gap;
    req_data <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      gap = $urandom_range(1, 25);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    if (req_valid) req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic fill_while_held();
    hold_ticket <= hold_ticket + 1;
    repeat (10) offer(date_req($urandom_range(2, 300), $urandom_range(0, 4095),
                               $urandom_range(0, 15), $urandom_range(0, 63)));
  endtask

  // receiver stall pattern
  initial begin
    int seen;
    int unsigned mode;
    int unsigned span;
    seen = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_ticket != seen) begin
        seen = hold_ticket;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 120);
        while (span != 0 && hold_ticket == seen) begin
          case (mode)
            0: res_stall <= 1'b0;
            1: res_stall <= 1'($urandom_range(0, 1));
            2: res_stall <= ($urandom_range(0, 3) == 0);
            default: res_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
          span--;
        end
      end
    end
  end

  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(date_req(0, 0, 1, 1));
    offer(date_req(0, 4095, 12, 31));
    offer(date_req(0, 4095, 12, 32));
    offer(date_req(0, 4095, 12, 63));
    offer(date_req(0, 2000, 2, 29));
    offer(date_req(0, 1900, 2, 29));
    offer(date_req(0, 2024, 2, 30));
    offer(date_req(0, 2023, 4, 31));
    offer(date_req(0, 100, 0, 5));
    offer(date_req(0, 100, 13, 5));
    offer(date_req(0, 100, 15, 63));
    offer(date_req(0, 2020, 6, 0));
    offer(date_req(1, 0, 0, 0));
    offer(date_req(2, 0, 0, 0));
    offer(date_req(60, 0, 0, 0));
    offer(date_req(61, 0, 0, 0));
    offer(date_req(400, 4095, 15, 63));
    offer(date_req(MAX_SERIAL_DAYS - 1, 0, 0, 0));
    offer(date_req(MAX_SERIAL_DAYS, 0, 0, 0));
    offer(date_req(20'hFFFFF, 4095, 15, 63));
    drain();

    fill_while_held();
    drain();

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      offer(random_request());
      if (i == 70) fill_while_held();
      if (i % 35 == 34) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    if (date_errors == 0 && outstanding == 0) begin
      $display("serial_day_to_calendar_date_core_tb OK");
    end else begin
      $display("serial_day_to_calendar_date_core_tb NOT OK");
    end
    $finish;
  end

endmodule
